>>> design/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types, operation codes and helper functions of the bit-field packer.
// ----------------------------------------------------------------------------
`default_nettype none

package bfp_pkg;

   // operation codes carried on the request tuser
   typedef enum logic [2:0] {
      FUNC_WRITE  = 3'd0,
      FUNC_READ   = 3'd1,
      FUNC_SKIP   = 3'd2,
      FUNC_ALIGN  = 3'd3,
      FUNC_SEEK   = 3'd4,
      FUNC_RESET  = 3'd5
   } func_type;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_BIG_ENDIAN = 1'b0;   // word index of the endian register

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // operation decoded at acceptance, consumed by the store stage
   typedef struct packed {
      logic        is_write;
      logic        is_read;
      logic        ok;
      logic [6:0]  num_bits;
      logic [2:0]  bit_off;
      logic [2:0]  byte_off;
      logic        swap_en;
      logic [3:0]  swap_bytes;
      logic [71:0] field;
      logic [12:0] byte_position;
      logic [2:0]  bit_position;
      logic [12:0] bytes_used;
   } op_type;

   // one result transaction
   typedef struct packed {
      logic [63:0] read_data;
      logic        ok;
      logic [12:0] byte_position;
      logic [2:0]  bit_position;
      logic [12:0] bytes_used;
   } rsp_type;

   // ones in the low n bits, n in 1..64
   function automatic logic [63:0] width_mask(input logic [6:0] n);
      logic [63:0] m;
      if (n[6]) begin
         m = '1;
      end else begin
         m = (64'd1 << n[5:0]) - 64'd1;
      end
      return m;
   endfunction

   // reverse the order of the low nb bytes
   function automatic logic [63:0] swap_low_bytes(input logic [63:0] v,
                                                  input logic [3:0]  nb);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < nb) begin
            r = r | (64'(v[8*i +: 8]) << (8 * (int'(nb) - 1 - i)));
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/bitstream_field_packer.sv
// A result passes through the stage 1 register and the result queue before it is presented.
// Throughput: one request transaction per cycle while req_tready is high (not during the
// clearing pass, not with the result queue full), the row banks read-modify-written with the last write forwarded.
// Reset: cursor and big_endian clear at once; the store then runs a clearing
// pass over both row banks, req_tready held low.
// ----------------------------------------------------------------------------
// bitstream_field_packer
// Packs and unpacks bit fields at a bit cursor over a byte store.
// ----------------------------------------------------------------------------
`default_nettype none

module bitstream_field_packer #(
   parameter int STORE_BYTES = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [87:0]                     req_tdata,  // value, num_bits, seek_byte, seek_bit
   input  wire logic [2:0]                      req_tuser,  // func
   // response channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [95:0]                          rsp_tdata,  // read_data, byte_position, bit_position, bytes_used
   output logic                                 rsp_tuser,  // ok
   // configuration port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [bfp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int ROW_W = $clog2(STORE_BYTES + 1) - 3;

   logic              big_endian_ff;
   logic              accept;
   logic              busy;
   logic              s1_valid;
   logic [ROW_W-1:0]  lo_row;
   logic [bfp_pkg::QCNT_W-1:0] q_count;
   logic [bfp_pkg::QCNT_W-1:0] in_flight;

   bfp_pkg::op_type  op;
   bfp_pkg::rsp_type result;
   bfp_pkg::rsp_type head;

   // request acceptance with room kept for everything in flight
   assign in_flight  = q_count + bfp_pkg::QCNT_W'(s1_valid);
   assign req_tready = !busy && (in_flight < bfp_pkg::QCNT_W'(bfp_pkg::QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   bfp_cursor #(
      .STORE_BYTES (STORE_BYTES)
   ) u_cursor (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_func      (req_tuser),
      .req_value     (req_tdata[63:0]),
      .req_num_bits  (req_tdata[71:64]),
      .req_seek_byte (req_tdata[84:72]),
      .req_seek_bit  (req_tdata[87:85]),
      .big_endian    (big_endian_ff),
      .op            (op),
      .lo_row        (lo_row)
   );

   bfp_store #(
      .STORE_BYTES (STORE_BYTES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .issue    (accept),
      .op       (op),
      .lo_row   (lo_row),
      .busy     (busy),
      .s1_valid (s1_valid),
      .result   (result)
   );

   bfp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid),
      .push_data (result),
      .pop       (rsp_tvalid && rsp_tready),
      .not_empty (rsp_tvalid),
      .head      (head),
      .count     (q_count)
   );

   // response packing
   assign rsp_tdata = {3'b000, head.bytes_used, head.bit_position,
                       head.byte_position, head.read_data};
   assign rsp_tuser = head.ok;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == bfp_pkg::REG_BIG_ENDIAN)) begin
         big_endian_ff <= csr_pwdata[0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == bfp_pkg::REG_BIG_ENDIAN)
                       ? {31'd0, big_endian_ff} : 32'd0;

endmodule

`default_nettype wire

>>> design/bfp_cursor.sv
// ----------------------------------------------------------------------------
// bfp_cursor
// Bit cursor state, range checks and field preparation at acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_cursor #(
   parameter int STORE_BYTES = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [2:0]                       req_func,
   input  wire logic [63:0]                      req_value,
   input  wire logic [7:0]                       req_num_bits,
   input  wire logic [12:0]                      req_seek_byte,
   input  wire logic [2:0]                       req_seek_bit,
   input  wire logic                             big_endian,
   output bfp_pkg::op_type                       op,
   output logic [$clog2(STORE_BYTES + 1) - 4:0]  lo_row
);

   localparam int CB_W  = $clog2(STORE_BYTES + 1);
   localparam int POS_W = CB_W + 3;
   localparam int CMP_W = (POS_W + 1 > 17) ? POS_W + 1 : 17;
   localparam logic [CMP_W-1:0] STORE_BITS = CMP_W'(STORE_BYTES * 8);

   logic [CB_W-1:0]  cursor_byte_ff, cursor_byte_in;
   logic [2:0]       cursor_bit_ff, cursor_bit_in;

   bfp_pkg::func_type func;
   logic [CMP_W-1:0] adv_pos;
   logic [CMP_W-1:0] seek_pos;
   logic             width_ok;
   logic             adv_fits;
   logic             seek_fits;
   logic             ok;
   logic [6:0]       n7;
   logic [63:0]      masked;
   logic [63:0]      swapped;
   logic             swap_en;
   logic [3:0]       swap_bytes;
   logic [31:0]      byte_wide;
   logic [31:0]      used_wide;

   assign func     = bfp_pkg::func_type'(req_func);
   assign adv_pos  = CMP_W'({cursor_byte_ff, cursor_bit_ff}) + CMP_W'(req_num_bits);
   assign seek_pos = CMP_W'({req_seek_byte, req_seek_bit});
   assign adv_fits = (adv_pos <= STORE_BITS);
   assign seek_fits = (seek_pos <= STORE_BITS);
   assign width_ok = (req_num_bits != 8'd0) && (req_num_bits <= 8'd64);
   assign n7       = req_num_bits[6:0];

   // next cursor and status per operation
   always_comb begin
      cursor_byte_in = cursor_byte_ff;
      cursor_bit_in  = cursor_bit_ff;
      ok             = 1'b0;
      unique case (func)
         bfp_pkg::FUNC_WRITE: begin
            if (width_ok && adv_fits) begin
               {cursor_byte_in, cursor_bit_in} = adv_pos[POS_W-1:0];
               ok = 1'b1;
            end
         end
         bfp_pkg::FUNC_READ: begin
            ok = width_ok && adv_fits;
         end
         bfp_pkg::FUNC_SKIP: begin
            if (adv_fits) begin
               {cursor_byte_in, cursor_bit_in} = adv_pos[POS_W-1:0];
               ok = 1'b1;
            end
         end
         bfp_pkg::FUNC_ALIGN: begin
            if (cursor_bit_ff != 3'd0) begin
               cursor_byte_in = cursor_byte_ff + CB_W'(1);
               cursor_bit_in  = 3'd0;
            end
            ok = 1'b1;
         end
         bfp_pkg::FUNC_SEEK: begin
            if (seek_fits) begin
               {cursor_byte_in, cursor_bit_in} = seek_pos[POS_W-1:0];
               ok = 1'b1;
            end
         end
         bfp_pkg::FUNC_RESET: begin
            cursor_byte_in = '0;
            cursor_bit_in  = 3'd0;
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // write field: mask, optional byte swap, bit alignment
   assign swap_en    = big_endian && (req_num_bits > 8'd8);
   assign swap_bytes = 4'((8'(n7) + 8'd7) >> 3);
   assign masked     = req_value & bfp_pkg::width_mask(n7);
   assign swapped    = swap_en ? bfp_pkg::swap_low_bytes(masked, swap_bytes) : masked;

   // position outputs reported on 13 bits
   assign byte_wide = 32'(cursor_byte_in);
   assign used_wide = 32'(cursor_byte_in) + 32'(cursor_bit_in != 3'd0);

   always_comb begin
      op.is_write      = (func == bfp_pkg::FUNC_WRITE) && ok;
      op.is_read       = (func == bfp_pkg::FUNC_READ) && ok;
      op.ok            = ok;
      op.num_bits      = n7;
      op.bit_off       = cursor_bit_ff;
      op.byte_off      = cursor_byte_ff[2:0];
      op.swap_en       = swap_en;
      op.swap_bytes    = swap_bytes;
      op.field         = 72'(swapped) << cursor_bit_ff;
      op.byte_position = byte_wide[12:0];
      op.bit_position  = cursor_bit_in;
      op.bytes_used    = used_wide[12:0];
   end

   assign lo_row = cursor_byte_ff[CB_W-1:3];

   // cursor state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_byte_ff <= '0;
         cursor_bit_ff  <= 3'd0;
      end else if (accept) begin
         cursor_byte_ff <= cursor_byte_in;
         cursor_bit_ff  <= cursor_bit_in;
      end
   end

endmodule

`default_nettype wire

>>> design/bfp_store.sv
// ----------------------------------------------------------------------------
// bfp_store
// Byte store in two 64-bit row banks with read-modify-write of the window.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_store #(
   parameter int STORE_BYTES = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             issue,
   input  wire bfp_pkg::op_type                  op,
   input  wire logic [$clog2(STORE_BYTES + 1) - 4:0] lo_row,
   output logic                                  busy,
   output logic                                  s1_valid,
   output bfp_pkg::rsp_type                      result
);

   localparam int ROWS       = STORE_BYTES / 8;
   localparam int BANK_ROWS  = ROWS / 2;
   localparam int BA_W       = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
   localparam int BANK_DEPTH = 1 << BA_W;

   // even rows in one bank, odd rows in the other
   logic [63:0] bank_even [BANK_DEPTH];
   logic [63:0] bank_odd  [BANK_DEPTH];

   logic [63:0] even_q_ff, odd_q_ff;

   logic            clearing_ff;
   logic [BA_W-1:0] clr_addr_ff;

   logic             s1_valid_ff;
   bfp_pkg::op_type  s1_op_ff;
   logic             s1_lo_bank_ff;
   logic             s1_hi_ok_ff;
   logic [BA_W-1:0]  s1_even_addr_ff, s1_odd_addr_ff;

   logic             fw_even_valid_ff, fw_odd_valid_ff;
   logic [BA_W-1:0]  fw_even_addr_ff, fw_odd_addr_ff;
   logic [63:0]      fw_even_data_ff, fw_odd_data_ff;

   logic [31:0]      half_row;
   logic [31:0]      even_row;
   logic [BA_W-1:0]  rd_even_addr, rd_odd_addr;
   logic             hi_ok;

   logic [63:0]  even_data, odd_data, lo_data, hi_data;
   logic [127:0] window;
   logic [127:0] merged;
   logic [63:0]  lo_new, hi_new;
   logic [63:0]  rd_masked;
   logic [63:0]  rd_field;
   logic         wr_lo, wr_hi;

   logic            we_even, we_odd;
   logic [BA_W-1:0] wa_even, wa_odd;
   logic [63:0]     wd_even, wd_odd;

   // row addresses of the two-row window at the cursor
   assign half_row     = 32'(lo_row) >> 1;
   assign even_row     = half_row + 32'(lo_row[0]);
   assign rd_even_addr = even_row[BA_W-1:0];
   assign rd_odd_addr  = half_row[BA_W-1:0];
   assign hi_ok        = (32'(lo_row) + 32'd1) < 32'(ROWS);

   // stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_op_ff        <= op;
         s1_lo_bank_ff   <= lo_row[0];
         s1_hi_ok_ff     <= hi_ok;
         s1_even_addr_ff <= rd_even_addr;
         s1_odd_addr_ff  <= rd_odd_addr;
      end
   end

   // take the write of the last edge when it hit the row just read
   assign even_data = (fw_even_valid_ff && (fw_even_addr_ff == s1_even_addr_ff))
                      ? fw_even_data_ff : even_q_ff;
   assign odd_data  = (fw_odd_valid_ff && (fw_odd_addr_ff == s1_odd_addr_ff))
                      ? fw_odd_data_ff : odd_q_ff;

   assign lo_data = s1_lo_bank_ff ? odd_data : even_data;
   assign hi_data = s1_hi_ok_ff ? (s1_lo_bank_ff ? even_data : odd_data) : 64'd0;
   assign window  = {hi_data, lo_data};

   // read extraction
   assign rd_masked = 64'(window >> {s1_op_ff.byte_off, s1_op_ff.bit_off})
                      & bfp_pkg::width_mask(s1_op_ff.num_bits);
   assign rd_field  = s1_op_ff.swap_en
                      ? bfp_pkg::swap_low_bytes(rd_masked, s1_op_ff.swap_bytes)
                      : rd_masked;

   // write merge
   assign merged = window | (128'(s1_op_ff.field) << {s1_op_ff.byte_off, 3'b000});
   assign lo_new = merged[63:0];
   assign hi_new = merged[127:64];
   assign wr_lo  = s1_valid_ff && s1_op_ff.is_write;
   assign wr_hi  = wr_lo && s1_hi_ok_ff;

   // bank write ports, the clearing pass has them alone
   always_comb begin
      if (clearing_ff) begin
         we_even = 1'b1;
         we_odd  = 1'b1;
         wa_even = clr_addr_ff;
         wa_odd  = clr_addr_ff;
         wd_even = 64'd0;
         wd_odd  = 64'd0;
      end else begin
         we_even = s1_lo_bank_ff ? wr_hi : wr_lo;
         we_odd  = s1_lo_bank_ff ? wr_lo : wr_hi;
         wa_even = s1_even_addr_ff;
         wa_odd  = s1_odd_addr_ff;
         wd_even = s1_lo_bank_ff ? hi_new : lo_new;
         wd_odd  = s1_lo_bank_ff ? lo_new : hi_new;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      even_q_ff <= bank_even[rd_even_addr];
      odd_q_ff  <= bank_odd[rd_odd_addr];
      if (we_even) begin
         bank_even[wa_even] <= wd_even;
      end
      if (we_odd) begin
         bank_odd[wa_odd] <= wd_odd;
      end
   end

   // last write per bank for forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_even_valid_ff <= 1'b0;
         fw_odd_valid_ff  <= 1'b0;
      end else begin
         fw_even_valid_ff <= we_even;
         fw_odd_valid_ff  <= we_odd;
      end
      fw_even_addr_ff <= wa_even;
      fw_odd_addr_ff  <= wa_odd;
      fw_even_data_ff <= wd_even;
      fw_odd_data_ff  <= wd_odd;
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + BA_W'(1);
         if (clr_addr_ff == BA_W'(BANK_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   assign busy     = clearing_ff;
   assign s1_valid = s1_valid_ff;

   always_comb begin
      result.read_data     = s1_op_ff.is_read ? rd_field : 64'd0;
      result.ok            = s1_op_ff.ok;
      result.byte_position = s1_op_ff.byte_position;
      result.bit_position  = s1_op_ff.bit_position;
      result.bytes_used    = s1_op_ff.bytes_used;
   end

endmodule

`default_nettype wire

>>> design/bfp_rsp_queue.sv
// ----------------------------------------------------------------------------
// bfp_rsp_queue
// Small result queue that decouples the store stage from the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module bfp_rsp_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire bfp_pkg::rsp_type              push_data,
   input  wire logic                          pop,
   output logic                               not_empty,
   output bfp_pkg::rsp_type                   head,
   output logic [bfp_pkg::QCNT_W-1:0]         count
);

   bfp_pkg::rsp_type entry_ff [bfp_pkg::QUEUE_DEPTH];

   logic [bfp_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bfp_pkg::QCNT_W-1:0] count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + bfp_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + bfp_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + bfp_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - bfp_pkg::QCNT_W'(1);
         end
      end
   end

   // entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire
